### rtl/xed_pkg.sv
// ----------------------------------------------------------------------------
// xed_pkg
// Shared types, constants and the entity name lookup for the entity decoder.
// ----------------------------------------------------------------------------
package xed_pkg;

  // name buffer sizing
  localparam int NAME_SLOTS  = 8;
  localparam int STORE_SLOTS = NAME_SLOTS - 1;
  localparam int CNT_W       = $clog2(NAME_SLOTS);
  localparam int IDX_W       = $clog2(STORE_SLOTS);

  // queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  typedef logic [7:0] byte_t;

  // special characters
  localparam byte_t CHAR_AMP  = 8'h26;
  localparam byte_t CHAR_SEMI = 8'h3B;
  localparam byte_t CHAR_LT   = 8'h3C;

  // known entity names and their characters
  localparam int ENT_COUNT = 6;
  localparam int ENT_MAX   = 4;
  localparam logic [2:0] ENT_LEN [ENT_COUNT] = '{3'd3, 3'd4, 3'd4, 3'd2, 3'd2, 3'd4};
  localparam byte_t ENT_TEXT [ENT_COUNT][ENT_MAX] = '{
    '{"a", "m", "p", 8'h00},
    '{"s", "e", "m", "i"},
    '{"q", "u", "o", "t"},
    '{"l", "t", 8'h00, 8'h00},
    '{"g", "t", 8'h00, 8'h00},
    '{"n", "b", "s", "p"}
  };
  localparam byte_t ENT_CHAR [ENT_COUNT] = '{"&", ";", 8'h22, "<", ">", " "};

  // channel words
  typedef struct packed {
    byte_t in_byte;
    logic  end_of_input;
  } in_word_t;

  typedef struct packed {
    byte_t out_byte;
    logic  finished;
  } out_word_t;

  // command kinds handed from front to back
  typedef logic [1:0] cmd_kind_t;
  localparam cmd_kind_t CMD_PASS   = 2'd0;
  localparam cmd_kind_t CMD_FINISH = 2'd1;
  localparam cmd_kind_t CMD_MATCH  = 2'd2;

  typedef struct packed {
    cmd_kind_t                 kind;
    byte_t                     value;
    byte_t [STORE_SLOTS-1:0]   name;
    logic  [CNT_W-1:0]         count;
  } cmd_t;

  typedef struct packed {
    logic  hit;
    byte_t ch;
  } lookup_t;

  // all six names compared side by side; a name ends at count or at a zero byte
  function automatic lookup_t entity_lookup(input byte_t [STORE_SLOTS-1:0] name,
                                            input logic [CNT_W-1:0] count);
    lookup_t          res;
    logic             ok;
    logic [CNT_W-1:0] len;
    res = '0;
    for (int k = 0; k < ENT_COUNT; k++) begin
      len = CNT_W'(ENT_LEN[k]);
      ok  = (count >= len);
      for (int j = 0; j < ENT_MAX; j++) begin
        if (j < int'(ENT_LEN[k]) && name[j] != ENT_TEXT[k][j]) begin
          ok = 1'b0;
        end
      end
      // longer stored names must carry a zero right after the match
      for (int i = 0; i < STORE_SLOTS; i++) begin
        if (i == int'(ENT_LEN[k]) && count != len && name[i] != 8'h00) begin
          ok = 1'b0;
        end
      end
      if (ok && !res.hit) begin
        res.hit = 1'b1;
        res.ch  = ENT_CHAR[k];
      end
    end
    return res;
  endfunction

endpackage

### rtl/xed_front.sv
// ----------------------------------------------------------------------------
// xed_front
// Accepts input words, tracks entity state, collects name bytes and issues
// pass, finish and match commands into the queue.
// ----------------------------------------------------------------------------
module xed_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  xed_pkg::in_word_t in_data,
  input  logic              q_full,
  output logic              q_push,
  output xed_pkg::cmd_t     q_data
);
  import xed_pkg::*;

  logic                    in_entity;
  logic                    in_entity_next;
  logic [CNT_W-1:0]        count;
  logic [CNT_W-1:0]        count_next;
  byte_t [STORE_SLOTS-1:0] name;
  logic                    accept;
  logic                    store;

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;

  // classify the accepted word
  always_comb begin
    in_entity_next = in_entity;
    count_next     = count;
    store          = 1'b0;
    q_push         = 1'b0;
    q_data.kind    = CMD_PASS;
    q_data.value   = in_data.in_byte;
    q_data.name    = name;
    q_data.count   = count;
    if (accept) begin
      if (in_data.end_of_input) begin
        q_push         = 1'b1;
        q_data.kind    = CMD_FINISH;
        in_entity_next = 1'b0;
        count_next     = '0;
      end else if (in_entity) begin
        if (in_data.in_byte == CHAR_SEMI || count >= CNT_W'(STORE_SLOTS)) begin
          q_push         = 1'b1;
          q_data.kind    = CMD_MATCH;
          in_entity_next = 1'b0;
          count_next     = '0;
        end else begin
          store      = 1'b1;
          count_next = count + 1'b1;
        end
      end else if (in_data.in_byte == CHAR_LT) begin
        q_push      = 1'b1;
        q_data.kind = CMD_FINISH;
        count_next  = '0;
      end else if (in_data.in_byte == CHAR_AMP) begin
        in_entity_next = 1'b1;
        count_next     = '0;
      end else begin
        q_push = 1'b1;
      end
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      in_entity <= 1'b0;
      count     <= '0;
    end else begin
      in_entity <= in_entity_next;
      count     <= count_next;
    end
  end

  // name buffer
  always_ff @(posedge clk) begin
    if (store) begin
      name[count[IDX_W-1:0]] <= in_data.in_byte;
    end
  end

endmodule

### rtl/xed_queue.sv
// ----------------------------------------------------------------------------
// xed_queue
// Short command queue that lets front and back stall independently.
// ----------------------------------------------------------------------------
module xed_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  xed_pkg::cmd_t push_data,
  output logic          full,
  input  logic          pop,
  output logic          head_valid,
  output xed_pkg::cmd_t head_data
);
  import xed_pkg::*;

  cmd_t              mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QCNT_W-1:0] fill;
  logic              do_pop;

  assign full       = (fill == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (fill != '0);
  assign head_data  = mem[rptr];
  assign do_pop     = pop && head_valid;

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= (rptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rptr + 1'b1;
      end
      if (push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

### rtl/xed_back.sv
// ----------------------------------------------------------------------------
// xed_back
// Executes queued commands: passes bytes, signals finish, looks up entity
// names, and holds the result in the output register.
// ----------------------------------------------------------------------------
module xed_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               head_valid,
  input  xed_pkg::cmd_t      head_data,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_stall,
  output xed_pkg::out_word_t out_data
);
  import xed_pkg::*;

  lookup_t   look;
  logic      produce;
  out_word_t result;
  logic      load;

  assign look = entity_lookup(head_data.name, head_data.count);
  assign load = !out_valid || !out_stall;
  assign pop  = head_valid && load;

  // build the result word for the head command
  always_comb begin
    produce         = 1'b1;
    result.out_byte = head_data.value;
    result.finished = 1'b0;
    case (head_data.kind)
      CMD_PASS: begin
        result.out_byte = head_data.value;
      end
      CMD_FINISH: begin
        result.out_byte = '0;
        result.finished = 1'b1;
      end
      CMD_MATCH: begin
        produce         = look.hit;
        result.out_byte = look.ch;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= head_valid && produce;
    end
  end

  always_ff @(posedge clk) begin
    if (pop && produce) begin
      out_data <= result;
    end
  end

endmodule

### rtl/xml_entity_decoder.sv
// ----------------------------------------------------------------------------
// xml_entity_decoder
// Character entity decoder for a byte stream, one byte per word.
// ----------------------------------------------------------------------------
// One input word is taken every cycle while the queue between the front and
// the back has room; the queue fills only while the output side stalls. A
// result passes through the front into the two-entry command queue and then
// through the name lookup into the output register. Plain bytes come out
// unchanged, an entity between '&' and ';' comes out as its character when it
// is amp, semi, quot, lt, gt or nbsp and as nothing otherwise, and '<' outside
// an entity or end of input gives a finished word with a zero byte.
module xml_entity_decoder (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  xed_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output xed_pkg::out_word_t out_data
);
  import xed_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_head_valid;
  cmd_t q_push_data;
  cmd_t q_head_data;

  // accept and classify
  xed_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_data   (q_push_data)
  );

  // command queue
  xed_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_data  (q_push_data),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_data  (q_head_data)
  );

  // execute and drive results
  xed_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (q_head_valid),
    .head_data  (q_head_data),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data)
  );

  // no command is pushed into a full queue
  assert property (@(posedge clk) disable iff (rst) q_push |-> !q_full)
    else $error("push into full command queue");

  // a stalled result holds the queue head in place
  assert property (@(posedge clk) disable iff (rst) (out_valid && out_stall) |-> !q_pop)
    else $error("queue popped while result stalled");

  // a finished word always carries a zero byte
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_data.finished) |-> (out_data.out_byte == 8'h00))
    else $error("finished word with nonzero byte");

endmodule

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the character entity decoder. Byte streams of plain
// text, known and unknown entities, overlong names, names cut by a zero byte
// and early end of input are pushed through the input channel with random
// gaps while the output side stalls at random. A scoreboard predicts every
// output word and checks each accepted one field by field.
// ----------------------------------------------------------------------------
module tb;
  import xed_pkg::*;

  localparam int WORD_TARGET = 550;
  localparam int IDLE_LIMIT  = 1000;

  // tracks entity decoding and holds the words still due at the output
  class entity_scoreboard;
    bit          in_entity = 1'b0;
    byte_t       name_buf [STORE_SLOTS];
    int unsigned name_len = 0;
    out_word_t   expected_words [$];
    int unsigned errors = 0;
    int unsigned words_checked = 0;
    int unsigned entities_decoded = 0;
    int unsigned finishes_seen = 0;

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    // resolve the collected name, stopping at the first zero byte
    function bit resolve_name(output byte_t ch);
      int unsigned len;
      logic [31:0] key;
      len = 0;
      key = '0;
      ch  = 8'h00;
      while (len < name_len && len < STORE_SLOTS && name_buf[len] != 8'h00) begin
        len++;
      end
      if (len > 4) begin
        return 1'b0;
      end
      for (int i = 0; i < len; i++) begin
        key = {key[23:0], name_buf[i]};
      end
      case (key)
        "amp":   ch = CHAR_AMP;
        "semi":  ch = CHAR_SEMI;
        "quot":  ch = 8'h22;
        "lt":    ch = CHAR_LT;
        "gt":    ch = ">";
        "nbsp":  ch = " ";
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    function void expect_word(byte_t b, logic fin);
      out_word_t w;
      w.out_byte = b;
      w.finished = fin;
      expected_words.push_back(w);
    endfunction

    // close the open entity and emit its character on a match
    function void close_entity();
      byte_t ch;
      if (resolve_name(ch)) begin
        expect_word(ch, 1'b0);
        entities_decoded++;
      end
      in_entity = 1'b0;
      name_len  = 0;
    endfunction

    // note one accepted input word
    function void note_word(in_word_t w);
      byte_t b;
      b = w.in_byte;
      if (w.end_of_input) begin
        in_entity = 1'b0;
        name_len  = 0;
        expect_word(8'h00, 1'b1);
      end else if (in_entity) begin
        if (b == CHAR_SEMI || name_len >= STORE_SLOTS) begin
          close_entity();
        end else begin
          name_buf[name_len] = b;
          name_len++;
        end
      end else if (b == CHAR_LT) begin
        name_len = 0;
        expect_word(8'h00, 1'b1);
      end else if (b == CHAR_AMP) begin
        in_entity = 1'b1;
        name_len  = 0;
      end else begin
        expect_word(b, 1'b0);
      end
    endfunction

    // compare one accepted output word with the oldest one due
    task check_word(out_word_t got);
      out_word_t want;
      if (expected_words.size() == 0) begin
        report($sformatf("unexpected word byte=%02h finished=%0b",
                         got.out_byte, got.finished));
      end else begin
        want = expected_words.pop_front();
        words_checked++;
        if (want.finished) begin
          finishes_seen++;
        end
        if (got.out_byte != want.out_byte) begin
          report($sformatf("word %0d out_byte %02h, want %02h",
                           words_checked, got.out_byte, want.out_byte));
        end
        if (got.finished != want.finished) begin
          report($sformatf("word %0d finished %0b, want %0b",
                           words_checked, got.finished, want.finished));
        end
      end
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_data;

  entity_scoreboard sb = new;
  string       known_names [6] = '{"amp", "semi", "quot", "lt", "gt", "nbsp"};
  bit          in_steady = 1'b0;
  int unsigned words_sent = 0;
  int unsigned idle_cycles = 0;

  xml_entity_decoder dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  // clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(15, 40);
  endfunction

  // any byte but the entity terminator
  function automatic byte_t name_byte();
    byte_t b;
    b = byte_t'($urandom_range(0, 255));
    if (b == CHAR_SEMI) begin
      b = b ^ 8'h01;
    end
    return b;
  endfunction

  // drive one word and wait until it is taken
  task automatic push_word(input byte_t b, input logic eoi);
    int unsigned gap;
    in_word_t    w;
    gap = in_steady ? 0 : gap_len();
    w.in_byte      = b;
    w.end_of_input = eoi;
    if (gap != 0) begin
      in_valid <= 1'b0;
      in_data  <= in_word_t'($urandom);
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    words_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      push_word(byte_t'(s[i]), 1'b0);
    end
  endtask

  // one random stretch of stream, mostly well-formed entities and text
  task automatic random_chunk();
    int unsigned pick;
    int unsigned n;
    string       nm;
    pick = $urandom_range(0, 99);
    nm   = known_names[$urandom_range(0, 5)];
    if (pick < 35) begin
      n = $urandom_range(1, 6);
      repeat (n) push_word(byte_t'($urandom_range(0, 255)), 1'b0);
    end else if (pick < 65) begin
      push_word(CHAR_AMP, 1'b0);
      send_text(nm);
      push_word(CHAR_SEMI, 1'b0);
    end else if (pick < 72) begin
      // known name cut short by a zero byte, junk after it
      push_word(CHAR_AMP, 1'b0);
      send_text(nm);
      push_word(8'h00, 1'b0);
      n = $urandom_range(0, STORE_SLOTS - 1 - nm.len());
      repeat (n) push_word(name_byte(), 1'b0);
      if (nm.len() + 1 + n == STORE_SLOTS && $urandom_range(0, 1) == 1) begin
        push_word(name_byte(), 1'b0);
      end else begin
        push_word(CHAR_SEMI, 1'b0);
      end
    end else if (pick < 78) begin
      // lowercase name, usually unknown
      push_word(CHAR_AMP, 1'b0);
      n = $urandom_range(0, STORE_SLOTS);
      repeat (n) push_word(byte_t'($urandom_range(8'h61, 8'h7a)), 1'b0);
      push_word(CHAR_SEMI, 1'b0);
    end else if (pick < 84) begin
      // name overruns the buffer
      push_word(CHAR_AMP, 1'b0);
      repeat (STORE_SLOTS + 1) push_word(name_byte(), 1'b0);
    end else if (pick < 88) begin
      // '<' taken as a name byte
      push_word(CHAR_AMP, 1'b0);
      n = $urandom_range(0, 2);
      repeat (n) push_word(byte_t'($urandom_range(8'h61, 8'h7a)), 1'b0);
      push_word(CHAR_LT, 1'b0);
      push_word(CHAR_SEMI, 1'b0);
    end else if (pick < 92) begin
      // end of input inside an entity
      push_word(CHAR_AMP, 1'b0);
      n = $urandom_range(0, STORE_SLOTS - 1);
      repeat (n) push_word(name_byte(), 1'b0);
      push_word(byte_t'($urandom_range(0, 255)), 1'b1);
    end else if (pick < 96) begin
      push_word(CHAR_LT, 1'b0);
    end else begin
      push_word(byte_t'($urandom_range(0, 255)), 1'b1);
    end
  endtask

  // scoreboard taps on both channels
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      sb.note_word(in_data);
    end
    if (!rst && out_valid && !out_stall) begin
      sb.check_word(out_data);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles", idle_cycles);
      $display("CHECK FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // output back-pressure: runs of ready cycles broken by stalls
  initial begin
    int unsigned run;
    wait (!rst);
    forever begin
      run = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 150) : $urandom_range(1, 8);
      repeat (run) @(posedge clk);
      out_stall <= 1'b1;
      repeat (gap_len() + 1) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // reset, directed words, random stream, drain
  initial begin
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // field extremes and plain-text stops
    push_word(8'h00, 1'b0);
    push_word(8'hFF, 1'b0);
    push_word(CHAR_LT, 1'b0);
    push_word(8'hFF, 1'b1);
    send_text("&lt;");
    // known name followed by a zero byte
    send_text("&gt");
    push_word(8'h00, 1'b0);
    push_word(CHAR_SEMI, 1'b0);
    // overlong name dropped silently
    send_text("&abcdefgh");
    // end of input in the middle of a name
    send_text("&q");
    push_word(8'h00, 1'b1);

    while (words_sent < WORD_TARGET) begin
      if ($urandom_range(0, 19) == 0) begin
        in_steady = !in_steady;
      end
      random_chunk();
    end
    in_valid <= 1'b0;

    while (sb.expected_words.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (sb.expected_words.size() != 0) begin
      sb.report($sformatf("%0d words never arrived", sb.expected_words.size()));
    end
    $display("sent %0d input words; checked %0d output words", words_sent,
             sb.words_checked);
    $display("%0d entities decoded, %0d finished words", sb.entities_decoded,
             sb.finishes_seen);
    if (sb.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/xed_pkg.sv
rtl/xed_front.sv
rtl/xed_queue.sv
rtl/xed_back.sv
rtl/xml_entity_decoder.sv
tb/tb.sv
